// ===== hw/rtl/fre_pkg.sv =====
// shared types and constants for the frame rate estimator
package fre_pkg;

	localparam int TIME_W   = 32;
	localparam int RATE_W   = 25;
	localparam int GAP_W    = 16;
	localparam int SUSP_W   = 4;
	localparam int FRAMES_W = 8;
	localparam int WIN_W    = 8;
	localparam int IDX_W    = 3;

	localparam int SCALE_W = 17;
	localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(100000);

	localparam int Q_DEPTH = 2;

	localparam logic [IDX_W-1:0] REG_START_RATE      = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_STALL_GAP_MS    = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_FAST_WINDOW_MS  = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_SLOW_WINDOW_MS  = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_MAX_SUSPENSIONS = IDX_W'(4);

	localparam logic [RATE_W-1:0] START_RATE_RST      = RATE_W'(3200);
	localparam logic [GAP_W-1:0]  STALL_GAP_MS_RST    = GAP_W'(250);
	localparam logic [GAP_W-1:0]  FAST_WINDOW_MS_RST  = GAP_W'(50);
	localparam logic [GAP_W-1:0]  SLOW_WINDOW_MS_RST  = GAP_W'(80);
	localparam logic [SUSP_W-1:0] MAX_SUSPENSIONS_RST = SUSP_W'(2);

	typedef struct packed {
		logic [GAP_W-1:0]  stall_gap_ms;
		logic [GAP_W-1:0]  fast_window_ms;
		logic [GAP_W-1:0]  slow_window_ms;
		logic [SUSP_W-1:0] max_suspensions;
	} cfg_t;

	typedef struct packed {
		logic                susp;
		logic                upd;
		logic [FRAMES_W-1:0] frames;
		logic [TIME_W-1:0]   dt;
		logic [WIN_W-1:0]    win;
	} cmd_t;

endpackage

// ===== hw/rtl/fre_front.sv =====
// front end: gap classification, window bookkeeping and window size adaptation
module fre_front #(
	parameter int MAX_WINDOW = 255
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fre_pkg::TIME_W-1:0]  time_ms,
	input  fre_pkg::cfg_t               cfg,
	input  logic                        q_full,
	output logic                        q_push,
	output fre_pkg::cmd_t               q_cmd
);

	localparam int WS_W = $clog2(MAX_WINDOW + 1);
	localparam int CW   = (WS_W > fre_pkg::FRAMES_W) ? WS_W : fre_pkg::FRAMES_W;

	logic [fre_pkg::TIME_W-1:0]   last_q;
	logic [fre_pkg::TIME_W-1:0]   wstart_q;
	logic [fre_pkg::FRAMES_W-1:0] frames_q;
	logic [WS_W-1:0]              ws_q;
	logic [fre_pkg::SUSP_W-1:0]   susp_q;

	logic                         accept;
	logic [fre_pkg::TIME_W-1:0]   gap;
	logic [fre_pkg::TIME_W-1:0]   dt;
	logic                         long_gap;
	logic                         drop;
	logic [fre_pkg::FRAMES_W-1:0] frames_inc;
	logic                         close;
	logic                         upd;
	logic [WS_W-1:0]              ws_adapt;
	logic [WS_W-1:0]              ws_next;
	logic [CW-1:0]                ws_ext;
	logic [CW-1:0]                ws_cur_ext;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	assign gap        = time_ms - last_q;
	assign long_gap   = (last_q != '0) && (time_ms > last_q) &&
		(gap > fre_pkg::TIME_W'(cfg.stall_gap_ms));
	assign drop       = long_gap && (susp_q < cfg.max_suspensions);
	assign frames_inc = frames_q + fre_pkg::FRAMES_W'(1);
	assign dt         = time_ms - wstart_q;
	assign close      = CW'(frames_inc) == CW'(ws_q);

	always_comb begin
		if (dt < fre_pkg::TIME_W'(cfg.fast_window_ms)) begin
			ws_adapt = (ws_q < WS_W'(MAX_WINDOW)) ? ws_q + WS_W'(1) : ws_q;
		end else if (dt > fre_pkg::TIME_W'(cfg.slow_window_ms)) begin
			ws_adapt = (ws_q > WS_W'(2)) ? ws_q - WS_W'(1) : WS_W'(2);
		end else begin
			ws_adapt = ws_q;
		end
	end

	assign ws_next    = close ? ws_adapt : ws_q;
	assign upd        = close && (dt != '0);
	assign ws_ext     = CW'(ws_next);
	assign ws_cur_ext = CW'(ws_q);

	assign q_push = accept;
	always_comb begin
		q_cmd.susp   = drop;
		q_cmd.upd    = !drop && upd;
		q_cmd.frames = frames_inc;
		q_cmd.dt     = dt;
		q_cmd.win    = drop ? ws_cur_ext[fre_pkg::WIN_W-1:0] : ws_ext[fre_pkg::WIN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			wstart_q <= '0;
			frames_q <= '0;
			ws_q     <= WS_W'(1);
			susp_q   <= '0;
		end else if (accept) begin
			last_q <= time_ms;
			if (drop) begin
				susp_q   <= susp_q + fre_pkg::SUSP_W'(1);
				wstart_q <= time_ms;
				frames_q <= '0;
			end else begin
				if (!long_gap) begin
					susp_q <= '0;
				end
				ws_q <= ws_next;
				if (upd) begin
					wstart_q <= time_ms;
					frames_q <= '0;
				end else begin
					frames_q <= frames_inc;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/fre_queue.sv =====
// short command queue between the front end and the rate unit
module fre_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fre_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output fre_pkg::cmd_t pop_cmd
);

	localparam int PW = $clog2(fre_pkg::Q_DEPTH);

	fre_pkg::cmd_t   entry_q [fre_pkg::Q_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full    = count_q == (PW + 1)'(fre_pkg::Q_DEPTH);
	assign valid   = count_q != '0;
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW + 1)'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/fre_back.sv =====
// rate unit: serial divider, rate smoothing and output register
module fre_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  fre_pkg::cmd_t               q_cmd,
	output logic                        q_pop,
	input  logic                        load_rate,
	input  logic [fre_pkg::RATE_W-1:0]  start_rate,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fre_pkg::RATE_W-1:0]  frame_rate,
	output logic                        rate_updated,
	output logic                        was_suspension,
	output logic [fre_pkg::WIN_W-1:0]   window_frames
);

	localparam int NUM_W = fre_pkg::RATE_W;
	localparam int CNT_W = $clog2(NUM_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_AVG
	} state_t;

	state_t                        state_q;
	logic [fre_pkg::RATE_W-1:0]    rate_q;
	logic [fre_pkg::FRAMES_W-1:0]  frames_q;
	logic [fre_pkg::TIME_W-1:0]    dt_q;
	logic [fre_pkg::WIN_W-1:0]     win_q;
	logic [NUM_W-1:0]              num_q;
	logic [fre_pkg::TIME_W-1:0]    rem_q;
	logic [CNT_W-1:0]              cnt_q;

	logic                          out_free;
	logic [NUM_W-1:0]              prod;
	logic [fre_pkg::TIME_W:0]      rem_sh;
	logic [fre_pkg::TIME_W:0]      rem_sub;
	logic                          ge;
	logic [fre_pkg::TIME_W-1:0]    rem_next;
	logic [fre_pkg::RATE_W:0]      sum;

	assign out_free = !out_valid || !out_stall;
	assign q_pop    = (state_q == ST_IDLE) && q_valid && out_free;

	assign prod     = NUM_W'(frames_q) * NUM_W'(fre_pkg::RATE_SCALE);
	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign ge       = rem_sh >= {1'b0, dt_q};
	assign rem_sub  = rem_sh - {1'b0, dt_q};
	assign rem_next = ge ? rem_sub[fre_pkg::TIME_W-1:0] : rem_sh[fre_pkg::TIME_W-1:0];
	assign sum      = {1'b0, rate_q} + {1'b0, num_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rate_q         <= fre_pkg::START_RATE_RST;
			out_valid      <= 1'b0;
			frame_rate     <= '0;
			rate_updated   <= 1'b0;
			was_suspension <= 1'b0;
			window_frames  <= '0;
			frames_q       <= '0;
			dt_q           <= '0;
			win_q          <= '0;
			num_q          <= '0;
			rem_q          <= '0;
			cnt_q          <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (load_rate) begin
				rate_q <= start_rate;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_cmd.upd) begin
							frames_q <= q_cmd.frames;
							dt_q     <= q_cmd.dt;
							win_q    <= q_cmd.win;
							state_q  <= ST_MUL;
						end else begin
							out_valid      <= 1'b1;
							frame_rate     <= rate_q;
							rate_updated   <= 1'b0;
							was_suspension <= q_cmd.susp;
							window_frames  <= q_cmd.win;
						end
					end
				end
				ST_MUL: begin
					num_q   <= prod;
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_next;
					num_q <= {num_q[NUM_W-2:0], ge};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					if (out_free) begin
						rate_q         <= sum[fre_pkg::RATE_W:1];
						out_valid      <= 1'b1;
						frame_rate     <= sum[fre_pkg::RATE_W:1];
						rate_updated   <= 1'b1;
						was_suspension <= 1'b0;
						window_frames  <= win_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/frame_rate_estimator.sv =====
// top level of the adaptive window frame rate estimator
// usage:
//   input channel in_valid/in_stall carries one frame timestamp time_ms per item;
//   output channel out_valid/out_stall returns one result item per input item,
//   in order: frame_rate (1/100 fps), rate_updated, was_suspension, window_frames.
//   configuration write port (cfg_write, cfg_index, cfg_data): the user writes
//   it only while the block is idle (unenforced); start_rate also loads the rate.
// timing:
//   the front end classifies an item in the cycle it is accepted and queues a
//   command (two entries). a frame that does not close a window passes from its
//   queue entry into the output register. a frame that closes a window is
//   dequeued, multiplied, then divided in 25 restoring divide steps and averaged.
//   sustained rate is one item per cycle for plain frames while the output is not
//   stalled; no new item is dequeued until a window close has been averaged.
// reset:
//   arst_n clears state: rate 3200, window size 1, counters and times zero,
//   registers to their default values.
// stall:
//   a stalled result holds in the output register; the queue keeps filling and
//   in_stall rises once it is full.
module frame_rate_estimator #(
	parameter int MAX_WINDOW = 255
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [fre_pkg::IDX_W-1:0]   cfg_index,
	input  logic [fre_pkg::RATE_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fre_pkg::TIME_W-1:0]  time_ms,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fre_pkg::RATE_W-1:0]  frame_rate,
	output logic                        rate_updated,
	output logic                        was_suspension,
	output logic [fre_pkg::WIN_W-1:0]   window_frames
);

	fre_pkg::cfg_t cfg_q;
	fre_pkg::cmd_t push_cmd;
	fre_pkg::cmd_t pop_cmd;
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	logic          load_rate;

	assign load_rate = cfg_write && (cfg_index == fre_pkg::REG_START_RATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stall_gap_ms    <= fre_pkg::STALL_GAP_MS_RST;
			cfg_q.fast_window_ms  <= fre_pkg::FAST_WINDOW_MS_RST;
			cfg_q.slow_window_ms  <= fre_pkg::SLOW_WINDOW_MS_RST;
			cfg_q.max_suspensions <= fre_pkg::MAX_SUSPENSIONS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				fre_pkg::REG_STALL_GAP_MS: begin
					cfg_q.stall_gap_ms <= cfg_data[fre_pkg::GAP_W-1:0];
				end
				fre_pkg::REG_FAST_WINDOW_MS: begin
					cfg_q.fast_window_ms <= cfg_data[fre_pkg::GAP_W-1:0];
				end
				fre_pkg::REG_SLOW_WINDOW_MS: begin
					cfg_q.slow_window_ms <= cfg_data[fre_pkg::GAP_W-1:0];
				end
				fre_pkg::REG_MAX_SUSPENSIONS: begin
					cfg_q.max_suspensions <= cfg_data[fre_pkg::SUSP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	fre_front #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.time_ms  (time_ms),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	fre_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.pop_cmd  (pop_cmd)
	);

	fre_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_cmd          (pop_cmd),
		.q_pop          (q_pop),
		.load_rate      (load_rate),
		.start_rate     (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_rate     (frame_rate),
		.rate_updated   (rate_updated),
		.was_suspension (was_suspension),
		.window_frames  (window_frames)
	);

endmodule
